@@ src/zad_pkg.sv @@
// ----------------------------------------------------------------------------
// zad_pkg: shared types and constants
// Transaction payload types and fixed field widths for the z-score detector.
// ----------------------------------------------------------------------------
package zad_pkg;

  localparam int VALUE_WIDTH     = 48;
  localparam int DEV_WIDTH       = VALUE_WIDTH - 1;
  localparam int Z_WIDTH         = 32;
  localparam int ZLIMIT_WIDTH    = 16;
  localparam int MAX_HISTORY_DEF = 64;
  localparam int FRAC_BITS       = 16;

  localparam logic [ZLIMIT_WIDTH-1:0] ZLIMIT_RESET = 16'd768;

  localparam logic ACTION_PUSH = 1'b0;
  localparam logic ACTION_EVAL = 1'b1;

  typedef struct packed {
    logic                          action;
    logic signed [VALUE_WIDTH-1:0] value;
  } item_t;

  typedef struct packed {
    logic                          enough_history;
    logic                          anomalous;
    logic signed [VALUE_WIDTH-1:0] mean_total;
    logic [DEV_WIDTH-1:0]          deviation;
    logic signed [Z_WIDTH-1:0]     zscore_value;
    logic signed [VALUE_WIDTH-1:0] judged_total;
    logic                          history_truncated;
  } result_t;

endpackage

@@ src/zad_alu.sv @@
// ----------------------------------------------------------------------------
// zad_alu: shared adder and subtractor
// One wide add or subtract with carry out, used for every arithmetic step.
// ----------------------------------------------------------------------------
module zad_alu #(
  parameter int WIDTH = 106
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] res,
  output logic             carry
);

  logic [WIDTH:0] full;

  // With subtraction the carry out is high exactly when a >= b.
  assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{WIDTH{1'b0}}, sub};
  assign res   = full[WIDTH-1:0];
  assign carry = full[WIDTH];

endmodule

@@ src/zad_core.sv @@
// ----------------------------------------------------------------------------
// zad_core: history store and evaluation sequencer
// Keeps the history, then walks it with the shared adder to form the mean,
// sample deviation, integer square root and z-score.
// ----------------------------------------------------------------------------
module zad_core
  import zad_pkg::*;
#(
  parameter int MAX_HISTORY = MAX_HISTORY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  item_t                   item,
  input  logic [ZLIMIT_WIDTH-1:0] zlimit,
  output logic                    ready,
  output logic                    done,
  input  logic                    take,
  output result_t                 result
);

  localparam int W       = VALUE_WIDTH;
  localparam int IDX_W   = $clog2(MAX_HISTORY);
  localparam int CNT_W   = $clog2(MAX_HISTORY + 1);
  localparam int SUM_W   = W + CNT_W;
  localparam int SQ_W    = 2 * (W + 1) + CNT_W;
  localparam int AW      = SQ_W + (SQ_W % 2);
  localparam int RT_W    = AW / 2;
  localparam int STEP_W  = $clog2(AW + 1);

  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(AW - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(AW / 2 - 1);
  localparam logic [STEP_W-1:0] SQ_LAST   = STEP_W'(W);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_HISTORY);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SNEG  = 5'd1;
  localparam logic [4:0] S_MDIV  = 5'd2;
  localparam logic [4:0] S_MSGN  = 5'd3;
  localparam logic [4:0] S_RD    = 5'd4;
  localparam logic [4:0] S_D1    = 5'd5;
  localparam logic [4:0] S_D2    = 5'd6;
  localparam logic [4:0] S_SQ    = 5'd7;
  localparam logic [4:0] S_VSET  = 5'd8;
  localparam logic [4:0] S_VDIV  = 5'd9;
  localparam logic [4:0] S_RSET  = 5'd10;
  localparam logic [4:0] S_SQRT  = 5'd11;
  localparam logic [4:0] S_MAG1  = 5'd12;
  localparam logic [4:0] S_MAG2  = 5'd13;
  localparam logic [4:0] S_MAGD  = 5'd14;
  localparam logic [4:0] S_ZDIV  = 5'd15;
  localparam logic [4:0] S_ZFIN  = 5'd16;
  localparam logic [4:0] S_FIVE1 = 5'd17;
  localparam logic [4:0] S_FIVE2 = 5'd18;
  localparam logic [4:0] S_DONE  = 5'd19;

  logic [4:0]        state;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  sum;
  logic              dropped;
  logic [W-1:0]      mem [MAX_HISTORY];
  logic [W-1:0]      rd_data;
  logic [IDX_W-1:0]  idx;
  logic [STEP_W-1:0] step;
  logic [AW-1:0]     acc;
  logic [AW-1:0]     shq;
  logic [AW-1:0]     mcand;
  logic [W:0]        mplier;
  logic [RT_W-1:0]   root;
  logic [RT_W-1:0]   dev;
  logic [W-1:0]      mean;
  logic [W-1:0]      value;
  logic [Z_WIDTH-1:0] zval;
  logic              sneg;
  logic              vneg;
  logic              enough;
  logic              anom;

  logic [AW-1:0]     alu_a;
  logic [AW-1:0]     alu_b;
  logic              alu_sub;
  logic [AW-1:0]     alu_res;
  logic              alu_carry;

  logic [AW-1:0]     sum_x;
  logic [AW-1:0]     mean_x;
  logic [AW-1:0]     div_a;
  logic [AW-1:0]     div_b;
  logic [AW-1:0]     rt_a;
  logic [CNT_W-1:0]  count_m1;
  logic [Z_WIDTH-1:0] zm;
  logic              mean_pos;

  zad_alu #(.WIDTH(AW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .res   (alu_res),
    .carry (alu_carry)
  );

  assign sum_x    = {{(AW-SUM_W){sum[SUM_W-1]}}, sum};
  assign mean_x   = {{(AW-W){mean[W-1]}}, mean};
  assign count_m1 = count - CNT_W'(1);
  assign div_a    = {acc[AW-2:0], shq[AW-1]};
  assign rt_a     = {acc[AW-3:0], shq[AW-1:AW-2]};
  assign mean_pos = !mean[W-1] && (|mean);
  // A quotient of 2^31 or more saturates the magnitude at 2^31.
  assign zm       = (|shq[AW-1:Z_WIDTH-1]) ? {1'b1, {(Z_WIDTH-1){1'b0}}}
                                           : {1'b0, shq[Z_WIDTH-2:0]};

  always_comb begin
    case (state)
      S_MDIV:  div_b = {{(AW-CNT_W){1'b0}}, count};
      S_VDIV:  div_b = {{(AW-CNT_W){1'b0}}, count_m1};
      default: div_b = {{(AW-RT_W){1'b0}}, dev};
    endcase
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state)
      S_IDLE: begin
        alu_a   = sum_x;
        alu_b   = {{(AW-W){item.value[W-1]}}, item.value};
        alu_sub = 1'b0;
      end
      S_SNEG: alu_b = sum_x;
      S_MDIV, S_VDIV, S_ZDIV: begin
        alu_a = div_a;
        alu_b = div_b;
      end
      S_MSGN: alu_b = shq;
      S_D1: begin
        alu_a = {{(AW-W){rd_data[W-1]}}, rd_data};
        alu_b = mean_x;
      end
      S_D2, S_MAG2: alu_b = mcand;
      S_SQ: begin
        alu_a   = acc;
        alu_b   = mcand;
        alu_sub = 1'b0;
      end
      S_SQRT: begin
        alu_a = rt_a;
        alu_b = {{(AW-RT_W-2){1'b0}}, root, 2'b01};
      end
      S_MAG1: begin
        alu_a = {{(AW-W){value[W-1]}}, value};
        alu_b = mean_x;
      end
      S_ZFIN: alu_b = {{(AW-Z_WIDTH){1'b0}}, zm};
      S_FIVE1: begin
        alu_a   = {mcand[AW-3:0], 2'b00};
        alu_b   = mcand;
        alu_sub = 1'b0;
      end
      S_FIVE2: begin
        alu_a = mean_x;
        alu_b = mcand;
      end
      default: alu_sub = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[idx];
    if (state == S_IDLE && start && item.action == ACTION_PUSH && count < CNT_MAX) begin
      mem[count[IDX_W-1:0]] <= item.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      sum     <= '0;
      dropped <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            if (item.action == ACTION_PUSH) begin
              if (count < CNT_MAX) begin
                count <= count + CNT_W'(1);
                sum   <= alu_res[SUM_W-1:0];
              end else begin
                dropped <= 1'b1;
              end
            end else begin
              value <= item.value;
              anom  <= 1'b0;
              zval  <= '0;
              if (count < CNT_W'(2)) begin
                enough <= 1'b0;
                mean   <= '0;
                dev    <= '0;
                state  <= S_DONE;
              end else begin
                enough <= 1'b1;
                state  <= S_SNEG;
              end
            end
          end
        end
        S_SNEG: begin
          sneg  <= sum[SUM_W-1];
          shq   <= sum[SUM_W-1] ? alu_res : sum_x;
          acc   <= '0;
          step  <= '0;
          state <= S_MDIV;
        end
        S_MDIV, S_VDIV, S_ZDIV: begin
          acc  <= alu_carry ? alu_res : div_a;
          shq  <= {shq[AW-2:0], alu_carry};
          step <= step + STEP_W'(1);
          if (step == DIV_LAST) begin
            case (state)
              S_MDIV:  state <= S_MSGN;
              S_VDIV:  state <= S_RSET;
              default: state <= S_ZFIN;
            endcase
          end
        end
        S_MSGN: begin
          mean  <= sneg ? alu_res[W-1:0] : shq[W-1:0];
          idx   <= '0;
          acc   <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_D1;
        S_D1: begin
          mcand  <= alu_res;
          mplier <= alu_res[W:0];
          step   <= '0;
          state  <= alu_res[AW-1] ? S_D2 : S_SQ;
        end
        S_D2: begin
          mcand  <= alu_res;
          mplier <= alu_res[W:0];
          state  <= S_SQ;
        end
        S_SQ: begin
          // Shift-and-add square of the distance into the running total.
          if (mplier[0]) begin
            acc <= alu_res;
          end
          mcand  <= {mcand[AW-2:0], 1'b0};
          mplier <= {1'b0, mplier[W:1]};
          step   <= step + STEP_W'(1);
          if (step == SQ_LAST) begin
            idx <= idx + IDX_W'(1);
            if ((CNT_W+1)'(idx) + (CNT_W+1)'(1) == {1'b0, count}) begin
              state <= S_VSET;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_VSET: begin
          shq   <= acc;
          acc   <= '0;
          step  <= '0;
          state <= S_VDIV;
        end
        S_RSET: begin
          acc   <= '0;
          root  <= '0;
          step  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          // Two radicand bits per step; the trial subtrahend is 4*root + 1.
          if (alu_carry) begin
            acc  <= alu_res;
            root <= {root[RT_W-2:0], 1'b1};
          end else begin
            acc  <= rt_a;
            root <= {root[RT_W-2:0], 1'b0};
          end
          shq  <= {shq[AW-3:0], 2'b00};
          step <= step + STEP_W'(1);
          if (step == SQRT_LAST) begin
            state <= S_MAG1;
          end
        end
        S_MAG1: begin
          dev   <= root;
          vneg  <= alu_res[AW-1];
          mcand <= alu_res;
          state <= alu_res[AW-1] ? S_MAG2 : S_MAGD;
        end
        S_MAG2: begin
          mcand <= alu_res;
          state <= S_MAGD;
        end
        S_MAGD: begin
          if (|dev) begin
            shq   <= {mcand[AW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
            acc   <= '0;
            step  <= '0;
            state <= S_ZDIV;
          end else if (mean_pos) begin
            state <= S_FIVE1;
          end else begin
            anom  <= !value[W-1] && (|value);
            state <= S_DONE;
          end
        end
        S_ZFIN: begin
          anom <= zm >= {{(Z_WIDTH-ZLIMIT_WIDTH-8){1'b0}}, zlimit, 8'h00};
          if (vneg) begin
            zval <= alu_res[Z_WIDTH-1:0];
          end else begin
            zval <= zm[Z_WIDTH-1] ? {1'b0, {(Z_WIDTH-1){1'b1}}} : zm;
          end
          state <= S_DONE;
        end
        S_FIVE1: begin
          mcand <= alu_res;
          state <= S_FIVE2;
        end
        S_FIVE2: begin
          anom  <= !alu_carry;
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            count   <= '0;
            sum     <= '0;
            dropped <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ready = (state == S_IDLE);
  assign done  = (state == S_DONE);

  always_comb begin
    result.enough_history    = enough;
    result.anomalous         = anom;
    result.mean_total        = mean;
    result.deviation         = (|dev[RT_W-1:DEV_WIDTH]) ? {DEV_WIDTH{1'b1}}
                                                        : dev[DEV_WIDTH-1:0];
    result.zscore_value      = zval;
    result.judged_total      = value;
    result.history_truncated = dropped;
  end

endmodule

@@ src/zscore_anomaly_detector.sv @@
// ----------------------------------------------------------------------------
// zscore_anomaly_detector: z-score outlier test on a stored cost history
// Each evaluation walks the stored totals on the one shared adder; with fewer
// than two totals it goes straight to the result.
// Throughput: one transaction at a time; input is stalled while evaluating.
// Reset (rst, synchronous) empties the history and restores the threshold to 3.0.
// ----------------------------------------------------------------------------
module zscore_anomaly_detector
  import zad_pkg::*;
#(
  parameter int MAX_HISTORY = MAX_HISTORY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  item_t                   item,
  output logic                    result_valid,
  input  logic                    result_stall,
  output result_t                 result,
  input  logic                    cfg_write,
  input  logic [ZLIMIT_WIDTH-1:0] cfg_data
);

  logic                    core_ready;
  logic                    core_done;
  logic                    take;
  result_t                 core_result;
  logic [ZLIMIT_WIDTH-1:0] zlimit;

  zad_core #(.MAX_HISTORY(MAX_HISTORY)) u_core (
    .clk    (clk),
    .rst    (rst),
    .start  (item_valid),
    .item   (item),
    .zlimit (zlimit),
    .ready  (core_ready),
    .done   (core_done),
    .take   (take),
    .result (core_result)
  );

  assign item_stall = !core_ready;
  assign take       = core_done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      zlimit       <= ZLIMIT_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        zlimit <= cfg_data;
      end
      if (take) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= core_result;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the z-score anomaly detector
// Push and evaluate transactions are predicted by a bit-accurate model of the
// history mean, sample deviation and z-score. Each result is checked field by
// field against the oldest prediction. Input gaps and result stalls are random.
// ----------------------------------------------------------------------------
module tb_top;
  import zad_pkg::*;

  localparam int  HIST_DEPTH  = MAX_HISTORY_DEF;
  localparam int  CYCLE_LIMIT = 1500000;
  localparam int  RANDOM_ITEMS = 1000;
  localparam logic [DEV_WIDTH-1:0] DEV_MAX = '1;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    item_valid = 1'b0;
  logic                    item_stall;
  item_t                   item = '0;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  result_t                 result;
  logic                    cfg_write = 1'b0;
  logic [ZLIMIT_WIDTH-1:0] cfg_data = '0;

  zscore_anomaly_detector u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // Model state of the detector.
  logic signed [VALUE_WIDTH-1:0] hist_vals [HIST_DEPTH];
  int                            hist_len;
  bit                            hist_dropped;
  logic [ZLIMIT_WIDTH-1:0]       z_limit;

  result_t verdict_queue[$];
  int      cycles;
  int      mismatches;
  int      verdicts_seen;
  int      anomalies_seen;
  int      items_sent;
  bit      calm;
  int      stall_left;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               verdict_queue.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Result side stall: short random stalls, with the odd long burst.
  always @(posedge clk) begin
    if (rst || calm) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      result_stall <= 1'b1;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 3) begin
      result_stall <= 1'b1;
      stall_left   <= $urandom_range(10, 60);
    end else begin
      result_stall <= ($urandom_range(0, 99) < 25);
    end
  end

  function automatic result_t judge_total(logic signed [VALUE_WIDTH-1:0] v);
    longint      total;
    longint      mean_l;
    longint      diff;
    logic [63:0] mag;
    logic [63:0] dev;
    logic [63:0] zm;
    logic [127:0] sq;
    logic [127:0] var_q;
    logic [127:0] root;
    logic [127:0] cand;
    logic [127:0] num;
    result_t     r;
    r = '0;
    r.judged_total      = v;
    r.history_truncated = hist_dropped;
    if (hist_len >= 2) begin
      r.enough_history = 1'b1;
      total = 0;
      for (int i = 0; i < hist_len; i++) total = total + longint'(hist_vals[i]);
      mean_l = total / hist_len;
      sq = '0;
      for (int i = 0; i < hist_len; i++) begin
        diff = longint'(hist_vals[i]) - mean_l;
        mag  = (diff < 0) ? -diff : diff;
        sq   = sq + {64'b0, mag} * {64'b0, mag};
      end
      var_q = sq / 128'(hist_len - 1);
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (128'd1 << b);
        if (cand * cand <= var_q) root = cand;
      end
      dev = root[63:0];
      r.deviation  = (dev > 64'(DEV_MAX)) ? DEV_MAX : dev[DEV_WIDTH-1:0];
      r.mean_total = mean_l[VALUE_WIDTH-1:0];
      diff = longint'(v) - mean_l;
      mag  = (diff < 0) ? -diff : diff;
      if (dev != 0) begin
        num = {64'b0, mag} << FRAC_BITS;
        if (num >= ({64'b0, dev} << 31)) zm = 64'd1 << 31;
        else zm = 64'(num / {64'b0, dev});
        r.anomalous = (zm >= {40'b0, z_limit, 8'b0});
        if (diff < 0) r.zscore_value = 32'd0 - zm[31:0];
        else r.zscore_value = (zm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : zm[31:0];
      end else if (mean_l > 0) begin
        r.anomalous = ({64'b0, mag} * 128'd5 > 128'(mean_l));
      end else begin
        r.anomalous = (v > 0);
      end
    end
    hist_len     = 0;
    hist_dropped = 0;
    return r;
  endfunction

  function automatic void note_transaction(item_t it);
    if (it.action == ACTION_PUSH) begin
      if (hist_len < HIST_DEPTH) begin
        hist_vals[hist_len] = it.value;
        hist_len++;
      end else begin
        hist_dropped = 1'b1;
      end
    end else begin
      verdict_queue.push_back(judge_total(it.value));
    end
  endfunction

  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Each call starts and ends just after a rising edge; valid is only lowered
  // when a gap follows, so it is never lowered and raised in one step.
  task automatic send_item(logic act, logic signed [VALUE_WIDTH-1:0] v);
    int     gap;
    item_t  it;
    gap = pick_gap();
    it.action = act;
    it.value  = v;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    note_transaction(it);
    items_sent++;
  endtask

  task automatic push_total(longint v);
    send_item(ACTION_PUSH, v[VALUE_WIDTH-1:0]);
  endtask

  task automatic judge(longint v);
    send_item(ACTION_EVAL, v[VALUE_WIDTH-1:0]);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_limit(logic [ZLIMIT_WIDTH-1:0] lim);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_write <= 1'b0;
    z_limit = lim;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      verdicts_seen++;
      if (verdict_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction: %p", result);
      end else begin
        automatic result_t want = verdict_queue.pop_front();
        if (result.anomalous) anomalies_seen++;
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch on result %0d:", verdicts_seen);
            $display("  expected enough=%b anom=%b mean=%0d dev=%0d z=%0d total=%0d trunc=%b",
                     want.enough_history, want.anomalous, want.mean_total, want.deviation,
                     want.zscore_value, want.judged_total, want.history_truncated);
            $display("  actual   enough=%b anom=%b mean=%0d dev=%0d z=%0d total=%0d trunc=%b",
                     result.enough_history, result.anomalous, result.mean_total,
                     result.deviation, result.zscore_value, result.judged_total,
                     result.history_truncated);
          end
        end
      end
    end
  end

  task automatic test_short_history();
    judge(0);
    push_total(5 << FRAC_BITS);
    judge(100 << FRAC_BITS);
  endtask

  // Constant history, zero deviation: 20 percent rule; if mean <= 0, total > 0.
  task automatic test_flat_history();
    repeat (3) push_total(100 << FRAC_BITS);
    judge(121 << FRAC_BITS);
    repeat (3) push_total(100 << FRAC_BITS);
    judge(120 << FRAC_BITS);
    repeat (2) push_total(0);
    judge(1);
    repeat (2) push_total(-(7 << FRAC_BITS));
    judge(0);
  endtask

  task automatic test_extremes();
    push_total((longint'(1) << 47) - 1);
    push_total(-(longint'(1) << 47));
    judge(-(longint'(1) << 47));
    push_total(0);
    push_total(1);
    judge((longint'(1) << 47) - 1);
    push_total(0);
    push_total(1);
    judge(-(longint'(1) << 47));
  endtask

  task automatic test_overflow();
    for (int i = 0; i < HIST_DEPTH + 6; i++) push_total(longint'(i) << FRAC_BITS);
    judge(0);
  endtask

  // Threshold set to 1.0, then to 0, then to its largest value 0xFFFF.
  task automatic test_threshold();
    set_limit(16'd256);
    push_total(0);
    push_total(2 << FRAC_BITS);
    judge(2 << FRAC_BITS);
    push_total(0);
    push_total(2 << FRAC_BITS);
    judge((2 << FRAC_BITS) - 1);
    set_limit(16'd0);
    push_total(3);
    push_total(9);
    judge(6);
    set_limit(16'hFFFF);
    push_total(0);
    push_total(1);
    judge(1 << 30);
  endtask

  task automatic random_sequence();
    int     roll;
    int     len;
    longint base;
    longint spread;
    longint v;
    roll = $urandom_range(0, 99);
    if (roll < 8) len = $urandom_range(0, 1);
    else if (roll < 12) len = $urandom_range(40, 80);
    else len = $urandom_range(2, 12);
    base   = longint'($signed($urandom_range(0, 32'h7FFF_FFFF))) - 64'sh3FFF_FFFF;
    base   = base * longint'($urandom_range(1, 1024));
    spread = longint'($urandom_range(1, 1 << $urandom_range(0, 24)));
    roll = $urandom_range(0, 99);
    for (int i = 0; i < len; i++) begin
      if (roll < 15) v = longint'({$urandom, $urandom});
      else if (roll < 30) v = base;
      else v = base + longint'($signed($urandom_range(0, 2000))) * spread / 1000 - spread;
      push_total(v);
    end
    if ($urandom_range(0, 9) == 0) v = longint'({$urandom, $urandom});
    else v = base + longint'($signed($urandom_range(0, 1200))) * spread / 100 - 6 * spread;
    judge(v);
  endtask

  task automatic test_random();
    int start;
    logic [ZLIMIT_WIDTH-1:0] lim;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        lim = $urandom_range(0, 9) < 7 ? 16'($urandom_range(64, 1024))
                                        : 16'($urandom_range(0, 16'hFFFF));
        set_limit(lim);
      end
      calm = ($urandom_range(0, 7) == 0);
      random_sequence();
    end
    calm = 1'b0;
  endtask

  initial begin
    hist_len = 0;
    hist_dropped = 0;
    z_limit = ZLIMIT_RESET;
    cycles = 0;
    mismatches = 0;
    verdicts_seen = 0;
    anomalies_seen = 0;
    items_sent = 0;
    calm = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_short_history();
    test_flat_history();
    test_extremes();
    test_overflow();
    test_threshold();
    set_limit(ZLIMIT_RESET);
    test_random();
    wait_drained();
    $display("Sent %0d transactions; checked %0d results, %0d flagged anomalous.",
             items_sent, verdicts_seen, anomalies_seen);
    $display("Threshold swept from 0 to 65535; mismatches: %0d.", mismatches);
    if (mismatches == 0 && verdict_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
